// ===== rtl/core/sira_pkg.sv =====
// ----------------------------------------------------------------------------
// sira_pkg
// Shared widths, character codes and helpers for the radix text converter.
// ----------------------------------------------------------------------------
package sira_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int RADIX_W        = 6;
  localparam int CHAR_W         = 8;
  localparam int LEN_W          = 6;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // Digits below ten map to '0'..'9', the rest to lower-case letters.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
    end
    return c;
  endfunction

  // Radix values outside two to thirty-six are pulled to the nearest end.
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] b;
    if (r < RADIX_MIN) begin
      b = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      b = RADIX_MAX;
    end else begin
      b = r;
    end
    return b;
  endfunction

endpackage

// ===== rtl/core/sira_div.sv =====
// ----------------------------------------------------------------------------
// sira_div
// Bit-serial restoring divider: one quotient bit per cycle, narrow remainder.
// ----------------------------------------------------------------------------
module sira_div #(
  parameter int DATA_WIDTH = sira_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [DATA_WIDTH-1:0]          dividend,
  input  logic [sira_pkg::RADIX_W-1:0]   divisor,
  output logic                           done,
  output logic [DATA_WIDTH-1:0]          quotient,
  output logic [sira_pkg::RADIX_W-1:0]   remainder
);
  import sira_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] q_r, q_nxt;
  logic [RADIX_W-1:0]    rem_r, rem_nxt;
  logic [RADIX_W-1:0]    dvs_r, dvs_nxt;
  logic [RADIX_W:0]      rem_sh;
  logic [RADIX_W:0]      dvs_ext;
  logic                  ge;

  // The dividend shifts out of the top of q_r while quotient bits enter below.
  assign rem_sh  = {rem_r, q_r[DATA_WIDTH-1]};
  assign dvs_ext = {1'b0, dvs_r};
  assign ge      = (rem_sh >= dvs_ext);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DATA_WIDTH - 1);
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      q_nxt   = {q_r[DATA_WIDTH-2:0], ge};
      rem_nxt = RADIX_W'(ge ? (rem_sh - dvs_ext) : rem_sh);
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

// ===== rtl/core/signed_int_to_radix_ascii_top.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_radix_ascii_top
// Converts one signed integer per item into its text in a configurable radix.
// ----------------------------------------------------------------------------
// Each input item carries one two's complement integer; the block writes its
// text in the radix held in the configuration register (reset 10, values
// below two act as two and values above thirty-six act as thirty-six) and
// sends it out one character per item, most significant character first.
// A negative value starts with '-', zero gives "0", and the most negative
// value is converted from its unsigned magnitude so it is right in any radix.
// Digits above nine are lower-case letters. The final character of a text
// carries tlast and the total text length; other characters carry length 0.
// The block handles one value at a time. Each digit comes from a bit-serial
// divider, and the characters then leave at up to one per cycle while the
// output is not stalled. Only one new item is taken while the block is idle;
// the last character may still sit in the output register when the next
// item is accepted. Configuration writes are always accepted and should be
// made only while the block is idle.
module signed_int_to_radix_ascii_top #(
  parameter int DATA_WIDTH = sira_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration write channel: radix register.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sira_pkg::RADIX_W-1:0]       cfg_data,
  // Input stream.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]    in_tdata,   // value, zero pad above
  // Result stream.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [15:0]                        out_tdata,  // character[7:0],
                                                         // text_length[13:8], pad
  output logic                               out_tlast   // last_char
);
  import sira_pkg::*;

  localparam int NCNT_W = $clog2(DATA_WIDTH + 1);
  localparam int IN_W   = ((DATA_WIDTH + 7) / 8) * 8;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_SIGN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [RADIX_W-1:0]    radix_r, radix_nxt;
  logic [RADIX_W-1:0]    base_r, base_nxt;
  logic                  neg_r, neg_nxt;
  logic [NCNT_W-1:0]     n_r, n_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [RADIX_W-1:0]    stk_r [DATA_WIDTH];
  logic [RADIX_W-1:0]    stk_nxt [DATA_WIDTH];

  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic [LEN_W-1:0]      out_len_r, out_len_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  accept;
  logic                  out_load;
  logic [DATA_WIDTH-1:0] in_val;
  logic                  in_neg;
  logic [DATA_WIDTH-1:0] in_mag;
  logic [NCNT_W-1:0]     n_inc;

  logic                  div_start;
  logic [DATA_WIDTH-1:0] div_dividend;
  logic [RADIX_W-1:0]    div_divisor;
  logic                  div_done;
  logic [DATA_WIDTH-1:0] div_quot;
  logic [RADIX_W-1:0]    div_rem;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  // The output register takes a new character whenever it is empty or drained.
  assign out_load  = !out_valid_r || out_tready;

  assign in_val = in_tdata[DATA_WIDTH-1:0];
  assign in_neg = in_val[DATA_WIDTH-1];
  assign in_mag = in_neg ? (~in_val + 1'b1) : in_val;
  assign n_inc  = n_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    radix_nxt     = radix_r;
    base_nxt      = base_r;
    neg_nxt       = neg_r;
    n_nxt         = n_r;
    len_nxt       = len_r;
    stk_nxt       = stk_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    div_start     = 1'b0;
    div_dividend  = div_quot;
    div_divisor   = base_r;

    if (cfg_valid && cfg_ready) begin
      radix_nxt = cfg_data;
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          base_nxt     = clamp_radix(radix_r);
          neg_nxt      = in_neg;
          n_nxt        = '0;
          div_start    = 1'b1;
          div_dividend = in_mag;
          div_divisor  = clamp_radix(radix_r);
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          // Push the new digit; the most significant digit ends up on top.
          stk_nxt[0] = div_rem;
          for (int i = 1; i < DATA_WIDTH; i++) begin
            stk_nxt[i] = stk_r[i-1];
          end
          n_nxt = n_inc;
          if ((div_quot != '0) && (n_inc != NCNT_W'(DATA_WIDTH))) begin
            div_start = 1'b1;
          end else begin
            len_nxt   = LEN_W'({1'b0, n_inc} + (NCNT_W + 1)'(neg_r));
            state_nxt = neg_r ? S_SIGN : S_EMIT;
          end
        end
      end
      S_SIGN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          out_len_nxt   = '0;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(stk_r[0]);
          out_last_nxt  = (n_r == NCNT_W'(1));
          out_len_nxt   = (n_r == NCNT_W'(1)) ? len_r : '0;
          for (int i = 0; i < DATA_WIDTH - 1; i++) begin
            stk_nxt[i] = stk_r[i+1];
          end
          stk_nxt[DATA_WIDTH-1] = '0;
          n_nxt = n_r - 1'b1;
          if (n_r == NCNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      radix_r     <= RADIX_RESET;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      radix_r     <= radix_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    neg_r      <= neg_nxt;
    len_r      <= len_nxt;
    stk_r      <= stk_nxt;
    out_char_r <= out_char_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

  sira_div #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot),
    .remainder(div_rem)
  );

  // Bits of the input word above the value width are ignored.
  logic unused_pad;
  assign unused_pad = ^{in_tdata, 1'b0} & (IN_W == 0);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_len_r, out_char_r};
  assign out_tlast  = out_last_r;

endmodule
